// File: sv/ust_pkg.sv
// shared types and codes for the unique set table
`timescale 1ns / 1ps
`default_nettype none

package ust_pkg;

   // fixed field widths of the stream words
   localparam int OP_W        = 2;
   localparam int ITEM_W      = 32;
   localparam int INDEX_W     = 6;
   localparam int STATUS_W    = 3;
   localparam int DATA_W      = 32;
   localparam int COUNT_OUT_W = 7;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 48;

   // operation codes
   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_SWAP_RD,
      S_SWAP_WR,
      S_READ_RD,
      S_READ_WAIT,
      S_RESP
   } state_type;

   // one finished result from the sequencer
   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [DATA_W-1:0]      read_data;
      logic [COUNT_OUT_W-1:0] entry_count;
   } result_type;

endpackage

`default_nettype wire

// File: sv/ust_ram.sv
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps
`default_nettype none

module ust_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/ust_ctrl.sv
// sequencer: linear search, append, swap-remove and indexed read over the entry ram
`timescale 1ns / 1ps
`default_nettype none

module ust_ctrl #(
   parameter int DEPTH       = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request word
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [ust_pkg::OP_W-1:0]     req_operation,
   input  wire logic [ust_pkg::ITEM_W-1:0]   req_item_value,
   input  wire logic [ust_pkg::INDEX_W-1:0]  req_read_index,
   // finished result
   output logic                              res_valid,
   input  wire logic                         res_ready,
   output ust_pkg::result_type               res_word,
   // entry ram
   output logic                              ram_wr_en,
   output logic [$clog2(DEPTH)-1:0]          ram_wr_addr,
   output logic [VALUE_WIDTH-1:0]            ram_wr_data,
   output logic [$clog2(DEPTH)-1:0]          ram_rd_addr,
   input  wire logic [VALUE_WIDTH-1:0]       ram_rd_data
);

   import ust_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;

   state_type state_ff, state_in;

   logic [OP_W-1:0]        op_ff, op_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [INDEX_W-1:0]     index_ff, index_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          ptr_ff, ptr_in;
   logic                   chk_ff, chk_in;
   logic [CW-1:0]          chk_ptr_ff, chk_ptr_in;
   logic [AW-1:0]          pos_ff, pos_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic [DATA_W-1:0]      data_ff, data_in;

   logic          accept;
   logic          hit;
   logic          scan_end;
   logic          full;
   logic          issue;
   logic          in_range;
   logic [CW-1:0] last_ptr;
   logic [XW-1:0] idx_ext;
   logic [XW-1:0] count_ext;

   // search and decode helpers
   assign accept    = req_valid && req_ready;
   assign hit       = chk_ff && (ram_rd_data == value_ff);
   assign scan_end  = !hit && (ptr_ff == count_ff);
   assign full      = (count_ff == CW'(DEPTH));
   assign issue     = (ptr_ff < count_ff);
   assign last_ptr  = count_ff - 1'b1;
   assign idx_ext   = XW'(index_ff);
   assign count_ext = XW'(count_ff);
   assign in_range  = (idx_ext < count_ext);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_operation)
                  OP_ADD, OP_REMOVE: state_in = S_SEARCH;
                  OP_READ:           state_in = S_READ_RD;
                  default:           state_in = S_RESP;
               endcase
            end
         end
         S_SEARCH: begin
            if (hit) begin
               state_in = (op_ff == OP_REMOVE) ? S_SWAP_RD : S_RESP;
            end else if (scan_end) begin
               state_in = S_RESP;
            end
         end
         S_SWAP_RD:   state_in = S_SWAP_WR;
         S_SWAP_WR:   state_in = S_RESP;
         S_READ_RD:   state_in = in_range ? S_READ_WAIT : S_RESP;
         S_READ_WAIT: state_in = S_RESP;
         S_RESP: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs: handshake and ram ports
   always_comb begin
      req_ready   = 1'b0;
      res_valid   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = count_ff[AW-1:0];
      ram_wr_data = value_ff;
      ram_rd_addr = ptr_ff[AW-1:0];
      unique case (state_ff)
         S_IDLE: req_ready = 1'b1;
         S_SEARCH: begin
            ram_rd_addr = ptr_ff[AW-1:0];
            ram_wr_en   = scan_end && (op_ff == OP_ADD) && !full;
            ram_wr_addr = count_ff[AW-1:0];
            ram_wr_data = value_ff;
         end
         S_SWAP_RD: ram_rd_addr = last_ptr[AW-1:0];
         S_SWAP_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_ff;
            ram_wr_data = ram_rd_data;
         end
         S_READ_RD:   ram_rd_addr = idx_ext[AW-1:0];
         S_READ_WAIT: ram_rd_addr = idx_ext[AW-1:0];
         S_RESP:      res_valid = 1'b1;
         default:     req_ready = 1'b0;
      endcase
   end

   // datapath next values
   always_comb begin
      op_in      = op_ff;
      value_in   = value_ff;
      index_in   = index_ff;
      count_in   = count_ff;
      ptr_in     = ptr_ff;
      chk_in     = chk_ff;
      chk_ptr_in = chk_ptr_ff;
      pos_in     = pos_ff;
      status_in  = status_ff;
      data_in    = data_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = req_operation;
               value_in  = VALUE_WIDTH'(req_item_value);
               index_in  = req_read_index;
               ptr_in    = '0;
               chk_in    = 1'b0;
               status_in = ST_DONE;
               data_in   = '0;
            end
         end
         S_SEARCH: begin
            // one entry issued and one compared per cycle
            ptr_in     = issue ? ptr_ff + 1'b1 : ptr_ff;
            chk_in     = issue;
            chk_ptr_in = ptr_ff;
            if (hit) begin
               pos_in = chk_ptr_ff[AW-1:0];
               if (op_ff == OP_ADD) begin
                  status_in = ST_PRESENT;
               end
            end else if (scan_end) begin
               if (op_ff == OP_ADD) begin
                  if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     count_in = count_ff + 1'b1;
                  end
               end else begin
                  status_in = ST_NOT_FOUND;
               end
            end
         end
         S_SWAP_WR: count_in = last_ptr;
         S_READ_RD: begin
            if (!in_range) begin
               status_in = ST_RANGE;
            end
         end
         S_READ_WAIT: data_in = DATA_W'(ram_rd_data);
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         chk_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         chk_ff   <= chk_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      value_ff   <= value_in;
      index_ff   <= index_in;
      ptr_ff     <= ptr_in;
      chk_ptr_ff <= chk_ptr_in;
      pos_ff     <= pos_in;
      status_ff  <= status_in;
      data_ff    <= data_in;
   end

   // result word
   assign res_word.status      = status_ff;
   assign res_word.read_data   = data_ff;
   assign res_word.entry_count = COUNT_OUT_W'(count_ff);

endmodule

`default_nettype wire

// File: sv/unique_set_table_top.sv
// Unique set table: holds up to DEPTH distinct values packed at the low
// positions of one entry ram, with a count. An add scans the stored entries
// one per cycle and appends the value if it is absent and the table is not
// full; a remove scans the same way and moves the last entry into the freed
// slot; a read returns the entry at an index below the count. Items are taken
// one at a time: the scan of an add or remove is paced by the single read
// port of the entry ram, which the scan walks one address per cycle. The
// result sits in an output register, so the next word is taken while the last
// result waits. Entries need no clearing after reset: only positions below the
// count are read.
`timescale 1ns / 1ps
`default_nettype none

module unique_set_table_top #(
   parameter int DEPTH       = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request stream
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // operation [1:0], item_value [33:2], read_index [39:34]
   input  wire logic [ust_pkg::REQ_TDATA_W-1:0] req_tdata,
   // result stream
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // status [2:0], read_data [34:3], entry_count [41:35], zero [47:42]
   output logic      [ust_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   import ust_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic                   ram_wr_en;
   logic [AW-1:0]          ram_wr_addr;
   logic [VALUE_WIDTH-1:0] ram_wr_data;
   logic [AW-1:0]          ram_rd_addr;
   logic [VALUE_WIDTH-1:0] ram_rd_data;

   logic       res_valid;
   logic       res_ready;
   result_type res_word;

   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   // sequencer
   ust_ctrl #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_operation  (req_tdata[1:0]),
      .req_item_value (req_tdata[33:2]),
      .req_read_index (req_tdata[39:34]),
      .res_valid      (res_valid),
      .res_ready      (res_ready),
      .res_word       (res_word),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data)
   );

   // entry store
   ust_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // output register load
   assign res_ready = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      if (res_ready) begin
         rsp_tvalid_in = res_valid;
         rsp_tdata_in  = RSP_TDATA_W'({res_word.entry_count, res_word.read_data,
                                       res_word.status});
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

`default_nettype wire

// File: verif/tb_unique_set_table_top.sv
// self-checking stream testbench for the unique set table with its own set predictor
`timescale 1ns / 1ps

module tb_unique_set_table_top;
   import ust_pkg::*;

   localparam int TABLE_DEPTH  = 64;
   localparam int ITEM_TARGET  = 1350;
   localparam int IDLE_LIMIT   = 5000;
   localparam int DRAIN_CYCLES = 120;

   // code three carries no operation
   localparam logic [OP_W-1:0] OP_NOP = 2'd3;

   typedef enum {TRAFFIC_FILL, TRAFFIC_DRAIN, TRAFFIC_MIX} traffic_kind_type;

   typedef struct {
      logic [OP_W-1:0]    op;
      logic [ITEM_W-1:0]  value;
      logic [INDEX_W-1:0] index;
      bit                 typed;
      result_type         want;
   } directed_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // operation [1:0], item_value [33:2], read_index [39:34]
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // status [2:0], read_data [34:3], entry_count [41:35], zero [47:42]
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // shadow copy of the table contents
   logic [ITEM_W-1:0] shadow_entries [TABLE_DEPTH];
   int                shadow_count = 0;

   result_type pending_results [$];
   int         error_count = 0;
   int         items_sent = 0;
   int         send_quiet = 0;
   int         recv_quiet = 0;
   int         idle_cycles = 0;

   // directed rows: fixed expectations only where trivially known
   directed_row_type directed_rows [25] = '{
      '{OP_READ,   32'h0000_0000, 6'd0,  1'b1, '{ST_RANGE,     32'h0,         7'd0}},
      '{OP_REMOVE, 32'h0000_0005, 6'd0,  1'b1, '{ST_NOT_FOUND, 32'h0,         7'd0}},
      '{OP_ADD,    32'h0000_0000, 6'd0,  1'b1, '{ST_DONE,      32'h0,         7'd1}},
      '{OP_ADD,    32'h0000_0000, 6'd0,  1'b1, '{ST_PRESENT,   32'h0,         7'd1}},
      '{OP_ADD,    32'hFFFF_FFFF, 6'd63, 1'b1, '{ST_DONE,      32'h0,         7'd2}},
      '{OP_READ,   32'h0000_0000, 6'd1,  1'b1, '{ST_DONE,      32'hFFFF_FFFF, 7'd2}},
      '{OP_READ,   32'hFFFF_FFFF, 6'd63, 1'b1, '{ST_RANGE,     32'h0,         7'd2}},
      '{OP_READ,   32'h0000_0000, 6'd2,  1'b1, '{ST_RANGE,     32'h0,         7'd2}},
      '{OP_NOP,    32'hAAAA_AAAA, 6'd63, 1'b1, '{ST_DONE,      32'h0,         7'd2}},
      '{OP_ADD,    32'h5555_5555, 6'd42, 1'b1, '{ST_DONE,      32'h0,         7'd3}},
      '{OP_ADD,    32'hAAAA_AAAA, 6'd21, 1'b1, '{ST_DONE,      32'h0,         7'd4}},
      '{OP_REMOVE, 32'h0000_0000, 6'd0,  1'b1, '{ST_DONE,      32'h0,         7'd3}},
      '{OP_READ,   32'h0000_0000, 6'd0,  1'b0, '{ST_DONE,      32'h0,         7'd0}},
      '{OP_REMOVE, 32'hAAAA_AAAA, 6'd0,  1'b0, '{ST_DONE,      32'h0,         7'd0}},
      '{OP_REMOVE, 32'hFFFF_FFFF, 6'd0,  1'b0, '{ST_DONE,      32'h0,         7'd0}},
      '{OP_READ,   32'h0000_0000, 6'd0,  1'b0, '{ST_DONE,      32'h0,         7'd0}},
      '{OP_READ,   32'h0000_0000, 6'd1,  1'b1, '{ST_RANGE,     32'h0,         7'd1}},
      '{OP_ADD,    32'h8000_0000, 6'd0,  1'b1, '{ST_DONE,      32'h0,         7'd2}},
      '{OP_ADD,    32'h0000_0001, 6'd0,  1'b1, '{ST_DONE,      32'h0,         7'd3}},
      '{OP_REMOVE, 32'h0000_0001, 6'd0,  1'b1, '{ST_DONE,      32'h0,         7'd2}},
      '{OP_ADD,    32'h5555_5555, 6'd0,  1'b1, '{ST_PRESENT,   32'h0,         7'd2}},
      '{OP_REMOVE, 32'h1234_5678, 6'd0,  1'b1, '{ST_NOT_FOUND, 32'h0,         7'd2}},
      '{OP_NOP,    32'hFFFF_FFFF, 6'd0,  1'b1, '{ST_DONE,      32'h0,         7'd2}},
      '{OP_READ,   32'h0000_0000, 6'd1,  1'b0, '{ST_DONE,      32'h0,         7'd0}},
      '{OP_REMOVE, 32'h8000_0000, 6'd0,  1'b0, '{ST_DONE,      32'h0,         7'd0}}
   };

   unique_set_table_top #(
      .DEPTH      (TABLE_DEPTH),
      .VALUE_WIDTH(32)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   // 10 ns clock
   initial begin
      forever #5 clock = ~clock;
   end

   // position of a value among the stored entries, -1 when absent
   function automatic int find_entry(logic [ITEM_W-1:0] value);
      for (int pos = 0; pos < shadow_count; pos++) begin
         if (shadow_entries[pos] == value) return pos;
      end
      return -1;
   endfunction

   // applies one operation to the shadow table and returns its result
   function automatic result_type apply_set_op(logic [OP_W-1:0] op, logic [ITEM_W-1:0] value,
                                               logic [INDEX_W-1:0] index);
      result_type res;
      int pos;
      res = '{ST_DONE, '0, '0};
      case (op)
         OP_ADD: begin
            if (find_entry(value) >= 0) begin
               res.status = ST_PRESENT;
            end else if (shadow_count >= TABLE_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               shadow_entries[shadow_count] = value;
               shadow_count++;
            end
         end
         OP_REMOVE: begin
            pos = find_entry(value);
            if (pos < 0) begin
               res.status = ST_NOT_FOUND;
            end else begin
               // last entry fills the hole
               shadow_entries[pos] = shadow_entries[shadow_count - 1];
               shadow_count--;
            end
         end
         OP_READ: begin
            if (int'(index) < shadow_count) begin
               res.read_data = shadow_entries[index];
            end else begin
               res.status = ST_RANGE;
            end
         end
         default: ;
      endcase
      res.entry_count = shadow_count[COUNT_OUT_W-1:0];
      return res;
   endfunction

   // wait length per word, with occasional runs of back-to-back words
   function automatic int draw_wait(inout int quiet_left);
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         quiet_left = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 11);
   endfunction

   // drives one request word and records its expected result at acceptance
   task automatic send_word(logic [OP_W-1:0] op, logic [ITEM_W-1:0] value,
                            logic [INDEX_W-1:0] index, bit typed, result_type want);
      int gap;
      result_type predicted;
      gap = draw_wait(send_quiet);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {index, value, op};
      do @(posedge clock); while (!req_tready);
      predicted = apply_set_op(op, value, index);
      pending_results.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   // value already in the table, or a fresh one when the table is empty
   function automatic logic [ITEM_W-1:0] stored_value();
      if (shadow_count == 0) return $urandom;
      return shadow_entries[$urandom_range(0, shadow_count - 1)];
   endfunction

   // random value, sometimes from a small pool so that collisions happen
   function automatic logic [ITEM_W-1:0] loose_value();
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, 15);
      return $urandom;
   endfunction

   // index mostly inside the table, sometimes anywhere
   function automatic logic [INDEX_W-1:0] pick_index();
      if (shadow_count > 0 && $urandom_range(0, 3) != 0) begin
         return INDEX_W'($urandom_range(0, shadow_count - 1));
      end
      return INDEX_W'($urandom_range(0, 63));
   endfunction

   // one random word shaped by the current traffic kind
   task automatic send_random(traffic_kind_type kind);
      int roll;
      logic [OP_W-1:0] op;
      logic [ITEM_W-1:0] value;
      roll  = $urandom_range(0, 99);
      value = loose_value();
      if (roll < 3) begin
         op = OP_NOP;
      end else begin
         case (kind)
            TRAFFIC_FILL: begin
               if (roll < 85) begin
                  op = OP_ADD;
               end else if (roll < 93) begin
                  op    = OP_ADD;
                  value = stored_value();
               end else begin
                  op = OP_READ;
               end
            end
            TRAFFIC_DRAIN: begin
               if (roll < 70) begin
                  op    = OP_REMOVE;
                  value = stored_value();
               end else if (roll < 85) begin
                  op = OP_REMOVE;
               end else begin
                  op = OP_READ;
               end
            end
            default: begin
               op = OP_W'($urandom_range(0, 2));
               if ($urandom_range(0, 1) == 1) value = stored_value();
            end
         endcase
      end
      send_word(op, value, pick_index(), 1'b0, '{ST_DONE, '0, '0});
   endtask

   // compares one accepted result against the oldest expectation
   task automatic check_result(logic [RSP_TDATA_W-1:0] word);
      result_type got;
      result_type want;
      got.status      = word[2:0];
      got.read_data   = word[34:3];
      got.entry_count = word[41:35];
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected result word %h", $time, word);
         error_count++;
         return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
         $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
         error_count++;
      end
      if (got.read_data !== want.read_data) begin
         $display("%0t: read_data expected %h actual %h", $time, want.read_data, got.read_data);
         error_count++;
      end
      if (got.entry_count !== want.entry_count) begin
         $display("%0t: entry_count expected %0d actual %0d", $time, want.entry_count,
                  got.entry_count);
         error_count++;
      end
      if (word[47:42] !== '0) begin
         $display("%0t: pad bits expected 0 actual %h", $time, word[47:42]);
         error_count++;
      end
   endtask

   // result side: random stalls, check each accepted word
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         stall = draw_wait(recv_quiet);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         check_result(rsp_tdata);
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("unique_set_table_top verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // reset, directed rows, random segments, drain
   initial begin
      traffic_kind_type kind;
      int seg_len;
      bit first_seg;
      first_seg = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].op, directed_rows[i].value, directed_rows[i].index,
                   directed_rows[i].typed, directed_rows[i].want);
      end

      // segments pick filling, draining or mixed traffic at random; the first one fills
      while (items_sent < ITEM_TARGET) begin
         if (first_seg) begin
            kind    = TRAFFIC_FILL;
            seg_len = 100;
         end else begin
            kind    = traffic_kind_type'($urandom_range(0, 2));
            seg_len = $urandom_range(20, 120);
         end
         first_seg = 1'b0;
         for (int n = 0; n < seg_len && items_sent < ITEM_TARGET; n++) begin
            send_random(kind);
         end
      end
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("unique_set_table_top verification clean");
      end else begin
         $display("unique_set_table_top verification failed");
      end
      $finish;
   end

endmodule
